// ===== sv/cp_pkg.sv =====
//------------------------------------------------------------------------------
// Cartesian-to-polar shared definitions
// Fixed-point constants, the arctangent table and the flag word that travels
// down the cell chain alongside the data.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

package cp_pkg;

  // fraction bits of the rotation datapath
  localparam int FRAC_BITS    = 24;
  // number of entries in the arctangent table
  localparam int ATAN_ENTRIES = 24;
  // angle accumulator width, units of pi/2^31
  localparam int Z_WIDTH      = 34;
  // width of the angle result, units of pi/2^15
  localparam int ANGLE_WIDTH  = 16;
  // accumulator bits dropped when forming the angle result
  localparam int ANGLE_SHIFT  = 16;

  localparam logic signed [Z_WIDTH-1:0] Z_QUARTER    = Z_WIDTH'(64'sh4000_0000);
  localparam logic signed [Z_WIDTH-1:0] Z_ROUND_HALF = Z_WIDTH'(64'sh0000_8000);

  typedef struct packed {
    logic y_zero;
    logic y_neg;
    logic x_neg;
  } cp_flags_t;

  // atan(2^-idx) in units of pi/2^31
  function automatic logic [31:0] atan_entry(input int idx);
    logic [31:0] val;
    case (idx)
      0:       val = 32'h2000_0000;
      1:       val = 32'h12E4_051E;
      2:       val = 32'h09FB_385B;
      3:       val = 32'h0511_11D4;
      4:       val = 32'h028B_0D43;
      5:       val = 32'h0145_D7E1;
      6:       val = 32'h00A2_F61E;
      7:       val = 32'h0051_7C55;
      8:       val = 32'h0028_BE53;
      9:       val = 32'h0014_5F2F;
      10:      val = 32'h000A_2F98;
      11:      val = 32'h0005_17CC;
      12:      val = 32'h0002_8BE6;
      13:      val = 32'h0001_45F3;
      14:      val = 32'h0000_A2FA;
      15:      val = 32'h0000_517D;
      16:      val = 32'h0000_28BE;
      17:      val = 32'h0000_145F;
      18:      val = 32'h0000_0A30;
      19:      val = 32'h0000_0518;
      20:      val = 32'h0000_028C;
      21:      val = 32'h0000_0146;
      22:      val = 32'h0000_00A3;
      23:      val = 32'h0000_0051;
      default: val = 32'h0000_0000;
    endcase
    return val;
  endfunction

endpackage

// ===== sv/cp_front.sv =====
//------------------------------------------------------------------------------
// Cartesian-to-polar front end
// Squares the coordinate magnitudes and sums them for the root chain, and
// pre-rotates the point into the right half plane for the angle chain.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module cp_front #(
  parameter int DATA_WIDTH = 16
) (
  input  logic                                            clk,
  input  logic                                            rst,
  input  logic                                            load,
  input  logic signed [DATA_WIDTH-1:0]                    x_coord,
  input  logic signed [DATA_WIDTH-1:0]                    y_coord,
  output logic                                            valid_out,
  output cp_pkg::cp_flags_t                               flags_out,
  output logic signed [DATA_WIDTH+cp_pkg::FRAC_BITS+2:0]  cx_out,
  output logic signed [DATA_WIDTH+cp_pkg::FRAC_BITS+2:0]  cy_out,
  output logic signed [cp_pkg::Z_WIDTH-1:0]               z_out,
  output logic        [2*DATA_WIDTH:0]                    rem_out
);
  import cp_pkg::*;

  localparam int CW = DATA_WIDTH + FRAC_BITS + 3;
  localparam int SW = 2 * DATA_WIDTH + 1;
  localparam int PW = 2 * DATA_WIDTH;

  logic [DATA_WIDTH-1:0]        ax;
  logic [DATA_WIDTH-1:0]        ay;
  logic signed [CW-1:0]         x_ext;
  logic signed [CW-1:0]         y_ext;
  logic signed [CW-1:0]         cx_next;
  logic signed [CW-1:0]         cy_next;
  logic signed [Z_WIDTH-1:0]    z_next;
  cp_flags_t                    flags_next;

  logic                         valid1;
  cp_flags_t                    flags1;
  logic [PW-1:0]                sq_x;
  logic [PW-1:0]                sq_y;
  logic signed [CW-1:0]         cx1;
  logic signed [CW-1:0]         cy1;
  logic signed [Z_WIDTH-1:0]    z1;

  assign ax = x_coord[DATA_WIDTH-1] ? (~x_coord + 1'b1) : x_coord;
  assign ay = y_coord[DATA_WIDTH-1] ? (~y_coord + 1'b1) : y_coord;

  assign x_ext = {{(CW-DATA_WIDTH-FRAC_BITS){x_coord[DATA_WIDTH-1]}}, x_coord,
                  {FRAC_BITS{1'b0}}};
  assign y_ext = {{(CW-DATA_WIDTH-FRAC_BITS){y_coord[DATA_WIDTH-1]}}, y_coord,
                  {FRAC_BITS{1'b0}}};

  assign flags_next.y_zero = (y_coord == '0);
  assign flags_next.y_neg  = y_coord[DATA_WIDTH-1];
  assign flags_next.x_neg  = x_coord[DATA_WIDTH-1];

  // quarter turn into the right half plane
  always_comb begin
    cx_next = x_ext;
    cy_next = y_ext;
    z_next  = '0;
    if (x_coord[DATA_WIDTH-1]) begin
      if (!y_coord[DATA_WIDTH-1] && (y_coord != '0)) begin
        cx_next = y_ext;
        cy_next = -x_ext;
        z_next  = Z_QUARTER;
      end else begin
        cx_next = -y_ext;
        cy_next = x_ext;
        z_next  = -Z_QUARTER;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1    <= 1'b0;
      valid_out <= 1'b0;
    end else begin
      valid1    <= load;
      valid_out <= valid1;
    end
  end

  always_ff @(posedge clk) begin
    flags1    <= flags_next;
    sq_x      <= PW'(ax) * PW'(ax);
    sq_y      <= PW'(ay) * PW'(ay);
    cx1       <= cx_next;
    cy1       <= cy_next;
    z1        <= z_next;
    flags_out <= flags1;
    rem_out   <= SW'(sq_x) + SW'(sq_y);
    cx_out    <= cx1;
    cy_out    <= cy1;
    z_out     <= z1;
  end

endmodule

// ===== sv/cp_cell.sv =====
//------------------------------------------------------------------------------
// Cartesian-to-polar chain cell
// One vectoring micro-rotation and one bit of the square root per cell; a
// cell past the end of either iteration passes that part through unchanged.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module cp_cell #(
  parameter int DATA_WIDTH = 16,
  parameter int ITERATIONS = 16,
  parameter int STAGE      = 0
) (
  input  logic                                            clk,
  input  logic                                            rst,
  input  logic                                            valid_in,
  input  cp_pkg::cp_flags_t                               flags_in,
  input  logic signed [DATA_WIDTH+cp_pkg::FRAC_BITS+2:0]  cx_in,
  input  logic signed [DATA_WIDTH+cp_pkg::FRAC_BITS+2:0]  cy_in,
  input  logic signed [cp_pkg::Z_WIDTH-1:0]               z_in,
  input  logic        [2*DATA_WIDTH:0]                    rem_in,
  input  logic        [2*DATA_WIDTH:0]                    root_in,
  output logic                                            valid_out,
  output cp_pkg::cp_flags_t                               flags_out,
  output logic signed [DATA_WIDTH+cp_pkg::FRAC_BITS+2:0]  cx_out,
  output logic signed [DATA_WIDTH+cp_pkg::FRAC_BITS+2:0]  cy_out,
  output logic signed [cp_pkg::Z_WIDTH-1:0]               z_out,
  output logic        [2*DATA_WIDTH:0]                    rem_out,
  output logic        [2*DATA_WIDTH:0]                    root_out
);
  import cp_pkg::*;

  localparam int CW = DATA_WIDTH + FRAC_BITS + 3;
  localparam int SW = 2 * DATA_WIDTH + 1;

  logic signed [CW-1:0]      cx_next;
  logic signed [CW-1:0]      cy_next;
  logic signed [Z_WIDTH-1:0] z_next;
  logic [SW-1:0]             rem_next;
  logic [SW-1:0]             root_next;

  if (STAGE < ITERATIONS && STAGE < ATAN_ENTRIES) begin : g_rot
    localparam logic signed [Z_WIDTH-1:0] ATAN = Z_WIDTH'(atan_entry(STAGE));
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic                 rot_up;

    assign dx     = cy_in >>> STAGE;
    assign dy     = cx_in >>> STAGE;
    // rotate clockwise only while y is strictly positive
    assign rot_up = !cy_in[CW-1] && (cy_in != '0);

    assign cx_next = rot_up ? (cx_in + dx) : (cx_in - dx);
    assign cy_next = rot_up ? (cy_in - dy) : (cy_in + dy);
    assign z_next  = rot_up ? (z_in + ATAN) : (z_in - ATAN);
  end else begin : g_rot_pass
    assign cx_next = cx_in;
    assign cy_next = cy_in;
    assign z_next  = z_in;
  end

  if (STAGE < DATA_WIDTH) begin : g_root
    localparam int            SHIFT = 2 * (DATA_WIDTH - 1 - STAGE);
    localparam logic [SW-1:0] BIT   = SW'(1) << SHIFT;
    logic [SW-1:0] trial;

    assign trial = root_in + BIT;

    always_comb begin
      if (rem_in >= trial) begin
        rem_next  = rem_in - trial;
        root_next = (root_in >> 1) + BIT;
      end else begin
        rem_next  = rem_in;
        root_next = root_in >> 1;
      end
    end
  end else begin : g_root_pass
    assign rem_next  = rem_in;
    assign root_next = root_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    flags_out <= flags_in;
    cx_out    <= cx_next;
    cy_out    <= cy_next;
    z_out     <= z_next;
    rem_out   <= rem_next;
    root_out  <= root_next;
  end

endmodule

// ===== sv/cp_back.sv =====
//------------------------------------------------------------------------------
// Cartesian-to-polar back end
// Rounds the root and the angle, clamps the angle to its range and applies
// the axis and sign rules before the result word is presented.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module cp_back #(
  parameter int DATA_WIDTH = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   valid_in,
  input  cp_pkg::cp_flags_t                      flags_in,
  input  logic signed [cp_pkg::Z_WIDTH-1:0]      z_in,
  input  logic        [2*DATA_WIDTH:0]           rem_in,
  input  logic        [2*DATA_WIDTH:0]           root_in,
  output logic                                   done,
  output logic        [DATA_WIDTH-1:0]           radius,
  output logic signed [cp_pkg::ANGLE_WIDTH-1:0]  angle
);
  import cp_pkg::*;

  localparam int SW = 2 * DATA_WIDTH + 1;
  localparam int AW = Z_WIDTH - ANGLE_SHIFT;

  localparam logic signed [AW-1:0] ANG_HI = AW'(2**(ANGLE_WIDTH-1) - 1);
  localparam logic signed [AW-1:0] ANG_LO = -AW'(2**(ANGLE_WIDTH-1));
  localparam logic signed [ANGLE_WIDTH-1:0] ANGLE_MAX = ANGLE_WIDTH'(ANG_HI);
  localparam logic signed [ANGLE_WIDTH-1:0] ANGLE_MIN = ANGLE_WIDTH'(ANG_LO);

  logic [SW-1:0]                root_rnd;
  logic signed [Z_WIDTH-1:0]    z_rnd;
  logic signed [AW-1:0]         ang_full;
  logic signed [ANGLE_WIDTH-1:0] angle_next;

  // round to nearest: step up when the remainder exceeds the root
  assign root_rnd = (rem_in > root_in) ? (root_in + 1'b1) : root_in;

  assign z_rnd    = z_in + Z_ROUND_HALF;
  assign ang_full = z_rnd[Z_WIDTH-1:ANGLE_SHIFT];

  always_comb begin
    if (ang_full > ANG_HI) begin
      angle_next = ANGLE_MAX;
    end else if (ang_full < ANG_LO) begin
      angle_next = ANGLE_MIN;
    end else begin
      angle_next = ang_full[ANGLE_WIDTH-1:0];
    end
    // keep the angle on the side of the axis that y is on
    if (!flags_in.y_neg && angle_next[ANGLE_WIDTH-1]) begin
      angle_next = '0;
    end
    if (flags_in.y_neg && !angle_next[ANGLE_WIDTH-1] && (angle_next != '0)) begin
      angle_next = '0;
    end
    if (flags_in.y_zero) begin
      angle_next = flags_in.x_neg ? ANGLE_MIN : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    radius <= root_rnd[DATA_WIDTH-1:0];
    angle  <= angle_next;
  end

endmodule

// ===== sv/cartesian_to_polar.sv =====
//------------------------------------------------------------------------------
// Cartesian-to-polar converter
// Pipelined magnitude and angle of a signed point by CORDIC vectoring.
//------------------------------------------------------------------------------
// Use: drive x_coord and y_coord and raise start for one cycle per word; a
// word is taken on every edge with start high, as busy stays low. Each word
// gives one result word on radius and angle, marked by done for one cycle.
// radius is round(sqrt(x*x + y*y)) at the input scale; angle counts pi/32768,
// with -32768 meaning -pi (negative x on the x axis) and 0 at the origin.
// Pipeline from the accepting edge to the done cycle: two front-end stages
// (squares and the quarter-turn pre-rotation, then the sum of the squares),
// one chain cell per step, and one rounding stage. Each cell does one
// micro-rotation and one root bit, so the chain length is set by the longer
// of the two.
// Throughput: one word per cycle, back to back.
// Reset clears the valid marks along the chain; words in flight are dropped.
// The receiver cannot stall: results leave on done whether or not they are
// wanted.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module cartesian_to_polar #(
  parameter int DATA_WIDTH = 16,
  parameter int ITERATIONS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [DATA_WIDTH-1:0]           x_coord,
  input  logic signed [DATA_WIDTH-1:0]           y_coord,
  output logic                                   done,
  output logic        [DATA_WIDTH-1:0]           radius,
  output logic signed [cp_pkg::ANGLE_WIDTH-1:0]  angle
);
  import cp_pkg::*;

  localparam int CW     = DATA_WIDTH + FRAC_BITS + 3;
  localparam int SW     = 2 * DATA_WIDTH + 1;
  localparam int NCELLS = (ITERATIONS > DATA_WIDTH) ? ITERATIONS : DATA_WIDTH;

  logic                      valid_c [0:NCELLS];
  cp_flags_t                 flags_c [0:NCELLS];
  logic signed [CW-1:0]      cx_c    [0:NCELLS];
  logic signed [CW-1:0]      cy_c    [0:NCELLS];
  logic signed [Z_WIDTH-1:0] z_c     [0:NCELLS];
  logic [SW-1:0]             rem_c   [0:NCELLS];
  logic [SW-1:0]             root_c  [0:NCELLS];

  // every cycle can take a word
  assign busy      = 1'b0;
  assign root_c[0] = '0;

  cp_front #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .load      (start),
    .x_coord   (x_coord),
    .y_coord   (y_coord),
    .valid_out (valid_c[0]),
    .flags_out (flags_c[0]),
    .cx_out    (cx_c[0]),
    .cy_out    (cy_c[0]),
    .z_out     (z_c[0]),
    .rem_out   (rem_c[0])
  );

  for (genvar i = 0; i < NCELLS; i++) begin : g_cell
    cp_cell #(
      .DATA_WIDTH(DATA_WIDTH),
      .ITERATIONS(ITERATIONS),
      .STAGE     (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .valid_in  (valid_c[i]),
      .flags_in  (flags_c[i]),
      .cx_in     (cx_c[i]),
      .cy_in     (cy_c[i]),
      .z_in      (z_c[i]),
      .rem_in    (rem_c[i]),
      .root_in   (root_c[i]),
      .valid_out (valid_c[i+1]),
      .flags_out (flags_c[i+1]),
      .cx_out    (cx_c[i+1]),
      .cy_out    (cy_c[i+1]),
      .z_out     (z_c[i+1]),
      .rem_out   (rem_c[i+1]),
      .root_out  (root_c[i+1])
    );
  end

  cp_back #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .valid_in (valid_c[NCELLS]),
    .flags_in (flags_c[NCELLS]),
    .z_in     (z_c[NCELLS]),
    .rem_in   (rem_c[NCELLS]),
    .root_in  (root_c[NCELLS]),
    .done     (done),
    .radius   (radius),
    .angle    (angle)
  );

endmodule

// ===== sim/cartesian_to_polar_checker.sv =====
//------------------------------------------------------------------------------
// Cartesian-to-polar result checker
// Watches the input and result channels of the converter. Every accepted
// input word is converted to its expected radius and angle. Every done cycle
// is compared against the oldest outstanding expectation.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module cartesian_to_polar_checker #(
  parameter int DATA_WIDTH = 16,
  parameter int ITERATIONS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic                                  busy,
  input  logic signed [DATA_WIDTH-1:0]          x_coord,
  input  logic signed [DATA_WIDTH-1:0]          y_coord,
  input  logic                                  done,
  input  logic        [DATA_WIDTH-1:0]          radius,
  input  logic signed [cp_pkg::ANGLE_WIDTH-1:0] angle,
  output int unsigned                           error_count,
  output int unsigned                           outstanding
);

  localparam int REPORT_LIMIT = 10;

  typedef struct {
    logic        [DATA_WIDTH-1:0]          radius;
    logic signed [cp_pkg::ANGLE_WIDTH-1:0] angle;
  } polar_t;

  // arctangent of 2^-i in units of pi/2^31
  localparam longint ATAN_PI31 [0:23] = '{
    64'h2000_0000, 64'h12E4_051E, 64'h09FB_385B, 64'h0511_11D4,
    64'h028B_0D43, 64'h0145_D7E1, 64'h00A2_F61E, 64'h0051_7C55,
    64'h0028_BE53, 64'h0014_5F2F, 64'h000A_2F98, 64'h0005_17CC,
    64'h0002_8BE6, 64'h0001_45F3, 64'h0000_A2FA, 64'h0000_517D,
    64'h0000_28BE, 64'h0000_145F, 64'h0000_0A30, 64'h0000_0518,
    64'h0000_028C, 64'h0000_0146, 64'h0000_00A3, 64'h0000_0051
  };

  polar_t      polar_queue[$];
  int unsigned result_index;

  function automatic polar_t polar_of(input logic signed [DATA_WIDTH-1:0] x,
                                      input logic signed [DATA_WIDTH-1:0] y);
    longint          xs, ys, cx, cy, z, t, dx, dy, ang;
    longint unsigned sq, root, rem, bitv;
    polar_t          p;
    xs = x;
    ys = y;

    // rounded square root, one result bit per step
    sq   = xs * xs + ys * ys;
    root = 0;
    rem  = sq;
    bitv = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (rem >= root + bitv) begin
        rem  = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    if (sq - root * root > root) root++;

    if (ys == 0) begin
      ang = (xs >= 0) ? 0 : -32768;
    end else begin
      cx = xs <<< cp_pkg::FRAC_BITS;
      cy = ys <<< cp_pkg::FRAC_BITS;
      z  = 0;
      // fold the left half plane onto the right by a quarter turn
      if (cx < 0) begin
        t = cx;
        if (cy > 0) begin
          cx = cy;
          cy = -t;
          z  = 64'sh4000_0000;
        end else begin
          cx = -cy;
          cy = t;
          z  = -64'sh4000_0000;
        end
      end
      for (int i = 0; i < ITERATIONS && i < cp_pkg::ATAN_ENTRIES; i++) begin
        dx = cy >>> i;
        dy = cx >>> i;
        if (cy > 0) begin
          cx = cx + dx;
          cy = cy - dy;
          z  = z + ATAN_PI31[i];
        end else begin
          cx = cx - dx;
          cy = cy + dy;
          z  = z - ATAN_PI31[i];
        end
      end
      ang = (z + 32768) >>> cp_pkg::ANGLE_SHIFT;
      if (ang > 32767) ang = 32767;
      if (ang < -32768) ang = -32768;
      // the sign of the angle follows y
      if (ys > 0 && ang < 0) ang = 0;
      if (ys < 0 && ang > 0) ang = 0;
    end

    p.radius = root[DATA_WIDTH-1:0];
    p.angle  = ang[cp_pkg::ANGLE_WIDTH-1:0];
    return p;
  endfunction

  always @(posedge clk) begin
    polar_t want;
    if (rst) begin
      polar_queue.delete();
      error_count  <= 0;
      result_index <= 0;
    end else begin
      if (start && !busy)
        polar_queue.insert(polar_queue.size(), polar_of(x_coord, y_coord));
      if (done) begin
        result_index <= result_index + 1;
        if (polar_queue.size() == 0) begin
          if (error_count < REPORT_LIMIT)
            $display("ERROR: result word %0d arrived with none outstanding: radius %0d angle %0d",
                     result_index, radius, angle);
          error_count <= error_count + 1;
        end else begin
          want = polar_queue.pop_front();
          if (radius !== want.radius || angle !== want.angle) begin
            if (error_count < REPORT_LIMIT)
              $display("ERROR: result word %0d: radius exp %0d got %0d, angle exp %0d got %0d",
                       result_index, want.radius, radius, want.angle, angle);
            error_count <= error_count + 1;
          end
        end
      end
    end
    outstanding <= polar_queue.size();
  end

endmodule

// ===== sim/tb_cartesian_to_polar.sv =====
//------------------------------------------------------------------------------
// Cartesian-to-polar testbench
// Feeds directed corner points, then random points with random gaps, into the
// converter. A checker beside the block predicts and compares every result.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_cartesian_to_polar;

  localparam int DATA_WIDTH   = 16;
  localparam int ITERATIONS   = 16;
  localparam int LATENCY      = ((ITERATIONS > DATA_WIDTH) ? ITERATIONS : DATA_WIDTH) + 3;
  localparam int RANDOM_WORDS = 630;
  localparam int IDLE_LIMIT   = 2000;

  logic                                  clk     = 1'b0;
  logic                                  rst     = 1'b1;
  logic                                  start   = 1'b0;
  logic signed [DATA_WIDTH-1:0]          x_coord = '0;
  logic signed [DATA_WIDTH-1:0]          y_coord = '0;
  logic                                  busy;
  logic                                  done;
  logic        [DATA_WIDTH-1:0]          radius;
  logic signed [cp_pkg::ANGLE_WIDTH-1:0] angle;
  int unsigned                           error_count;
  int unsigned                           outstanding;
  int unsigned                           idle_cycles;
  bit                                    burst;

  cartesian_to_polar #(
    .DATA_WIDTH(DATA_WIDTH),
    .ITERATIONS(ITERATIONS)
  ) i_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .x_coord(x_coord),
    .y_coord(y_coord),
    .done   (done),
    .radius (radius),
    .angle  (angle)
  );

  cartesian_to_polar_checker #(
    .DATA_WIDTH(DATA_WIDTH),
    .ITERATIONS(ITERATIONS)
  ) i_checker (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .x_coord    (x_coord),
    .y_coord    (y_coord),
    .done       (done),
    .radius     (radius),
    .angle      (angle),
    .error_count(error_count),
    .outstanding(outstanding)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // end the run when nothing moves on either channel for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // mostly no gap or a short one, now and then a long one
  function automatic int gap_length();
    int roll;
    roll = $urandom_range(0, 99);
    if (burst || roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [DATA_WIDTH-1:0] random_coord();
    logic signed [DATA_WIDTH-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: v = DATA_WIDTH'($urandom);
      5, 6:          v = DATA_WIDTH'($signed($urandom_range(0, 32)) - 16);
      7: begin
        case ($urandom_range(0, 4))
          0:       v = 16'sh7FFF;
          1:       v = 16'sh8000;
          2:       v = -16'sd1;
          3:       v = 16'sd1;
          default: v = 16'sd0;
        endcase
      end
      8:             v = DATA_WIDTH'((16'sd1 <<< $urandom_range(0, 14)) *
                                     ($urandom_range(0, 1) ? 1 : -1));
      default:       v = '0;
    endcase
    return v;
  endfunction

  // present one word and hold it until the converter takes it
  task automatic send_point(input logic signed [DATA_WIDTH-1:0] x,
                            input logic signed [DATA_WIDTH-1:0] y);
    int gap;
    gap = gap_length();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    x_coord <= x;
    y_coord <= y;
    start   <= 1'b1;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
  endtask

  initial begin
    logic signed [DATA_WIDTH-1:0] dir_x [0:21] = '{
      16'sd0, 16'sd32767, -16'sd32768, -16'sd1, 16'sd1, 16'sd0, 16'sd0,
      16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767, -16'sd32768,
      -16'sd32768, -16'sd1, -16'sd1, 16'sd1, 16'sd1, 16'sd32767, 16'sd32767,
      16'sd0, 16'sd0, -16'sd32767
    };
    logic signed [DATA_WIDTH-1:0] dir_y [0:21] = '{
      16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd32767, -16'sd32768,
      16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768, 16'sd1,
      -16'sd1, 16'sd1, -16'sd1, 16'sd1, -16'sd1, 16'sd1, -16'sd1,
      16'sd1, -16'sd1, 16'sd32767
    };
    int wait_cycles;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // corners: origin, both axes, diagonals, points just beside minus pi
    burst = 1'b0;
    for (int i = 0; i < 22; i++) send_point(dir_x[i], dir_y[i]);

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i % 50 == 0) burst = ($urandom_range(0, 3) == 0);
      send_point(random_coord(), random_coord());
    end
    start <= 1'b0;

    wait_cycles = 0;
    while (outstanding != 0 && wait_cycles < 4 * LATENCY + IDLE_LIMIT) begin
      @(posedge clk);
      wait_cycles++;
    end
    // drain anything stray still in the pipe
    repeat (2 * LATENCY) @(posedge clk);

    if (error_count == 0 && outstanding == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
